// ===== rtl/masked_gray_histogram_unit_assert.svh =====
// Assertion macros for the histogram RTL.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef MASKED_GRAY_HISTOGRAM_UNIT_ASSERT_SVH
`define MASKED_GRAY_HISTOGRAM_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MGH_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MGH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mgh_pkg.sv =====
// Shared constants, opcodes and types of the masked gray-level histogram.
// No dependencies; the bin map, the top unit and the testbench import this package.
`timescale 1ns / 1ps

package mgh_pkg;

    localparam int MAX_BINS_DEF    = 256;
    localparam int COUNT_WIDTH_DEF = 32;

    localparam int OP_W       = 2;
    localparam int PIX_W      = 8;
    localparam int BIN_IDX_W  = 8;
    localparam int CFG_W      = 9;
    localparam int OUT_W      = 32;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [OP_W-1:0] OP_ACCUM = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // Register word index, taken from paddr above the byte offset.
    localparam logic [APB_ADDR_W-3:0] REG_BIN_COUNT = 1'b0;
    localparam logic [CFG_W-1:0]      BIN_COUNT_RST = 9'd256;

    typedef struct packed {
        logic [BIN_IDX_W-1:0] bin;
        logic                 in_range;
    } bin_sel_t;

endpackage

// ===== rtl/mgh_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends only on its parameters; the bin store is an instance of it.
`timescale 1ns / 1ps

module mgh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/mgh_bin_map.sv =====
// Maps an item to the bin it touches: scales the pixel into the effective
// bin count, or range-checks the read index. Depends on mgh_pkg.
`timescale 1ns / 1ps

module mgh_bin_map #(
    parameter int MAX_BINS = mgh_pkg::MAX_BINS_DEF
) (
    input  logic [mgh_pkg::CFG_W-1:0] bin_count,
    input  logic [mgh_pkg::OP_W-1:0]  opcode,
    input  logic [mgh_pkg::PIX_W-1:0] pixel_value,
    input  logic [mgh_pkg::PIX_W-1:0] read_index,
    output mgh_pkg::bin_sel_t         sel
);

    import mgh_pkg::*;

    localparam int              PROD_W   = PIX_W + CFG_W;
    localparam logic [CFG_W-1:0] MAX_SIZE = CFG_W'(MAX_BINS);
    localparam logic [CFG_W-1:0] LAST_BIN = CFG_W'(MAX_BINS - 1);

    logic [CFG_W-1:0]  size;
    logic [PROD_W-1:0] prod;
    logic [CFG_W-1:0]  acc_bin;
    logic [CFG_W-1:0]  scaled;

    always_comb
    begin
        // A count of zero or beyond the store falls back to the full store.
        size    = (bin_count == '0 || bin_count > MAX_SIZE) ? MAX_SIZE : bin_count;
        prod    = PROD_W'(pixel_value) * PROD_W'(size);
        scaled  = prod[PROD_W-1:PIX_W];
        acc_bin = (scaled > LAST_BIN) ? LAST_BIN : scaled;

        if (opcode == OP_READ)
        begin
            sel.bin      = read_index;
            sel.in_range = (CFG_W'(read_index) < size);
        end
        else
        begin
            sel.bin      = acc_bin[BIN_IDX_W-1:0];
            sel.in_range = 1'b1;
        end
    end

endmodule

// ===== rtl/masked_gray_histogram_unit.sv =====
// A result is registered from the item held in execution once the output is free.
// Throughput: one item per cycle while results are taken; the bin RAM is read at
// acceptance and written back when the item executes, with a forward for the same bin.
// Clear and bin-count writes take effect through per-bin valid flags, not the RAM.
// Reset (rst_n, asynchronous): empty histogram, total zero, bin count 256.
`timescale 1ns / 1ps

`include "masked_gray_histogram_unit_assert.svh"

module masked_gray_histogram_unit #(
    parameter int MAX_BINS    = mgh_pkg::MAX_BINS_DEF,
    parameter int COUNT_WIDTH = mgh_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mgh_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [mgh_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mgh_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    input  logic                           item_valid,
    output logic                           item_ready,
    input  logic [mgh_pkg::OP_W-1:0]       opcode,
    input  logic [mgh_pkg::PIX_W-1:0]      pixel_value,
    input  logic                           pixel_counted,
    input  logic [mgh_pkg::PIX_W-1:0]      read_index,
    output logic                           result_valid,
    input  logic                           result_ready,
    output logic [mgh_pkg::OUT_W-1:0]      bin_value,
    output logic [mgh_pkg::OUT_W-1:0]      total_counted
);

    import mgh_pkg::*;

    localparam int BIN_AW = $clog2(MAX_BINS);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_W-1:0]       bin_count_reg;
    logic [MAX_BINS-1:0]    valid_reg, valid_next;
    logic [COUNT_WIDTH-1:0] pixel_total_reg, pixel_total_next;
    logic                   result_valid_reg, result_valid_next;
    logic [OUT_W-1:0]       bin_value_reg, total_counted_reg;

    // Item held while its bin is read and updated.
    logic [OP_W-1:0]        op_reg;
    logic                   counted_reg;
    logic [BIN_AW-1:0]      addr_reg;
    logic                   in_range_reg;
    logic                   rd_valid_reg;
    logic                   fwd_hit_reg;
    logic [COUNT_WIDTH-1:0] fwd_data_reg;

    bin_sel_t               sel;
    logic [BIN_AW-1:0]      rd_addr;
    logic                   cfg_wr, cfg_hit;
    logic                   item_fire, exec_go, clr_now;
    logic                   ram_we;
    logic [COUNT_WIDTH-1:0] ram_rdata, cur_val, inc_val, upd_val, bin_res, total_inc;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_hit = cfg_wr && (paddr[APB_ADDR_W-1:2] == REG_BIN_COUNT);
    assign prdata  = (paddr[APB_ADDR_W-1:2] == REG_BIN_COUNT)
                     ? APB_DATA_W'(bin_count_reg) : '0;

    assign exec_go    = (state_reg == S_EXEC) && (!result_valid_reg || result_ready);
    assign item_ready = (state_reg == S_IDLE) || exec_go;
    assign item_fire  = item_valid && item_ready;

    mgh_bin_map #(
        .MAX_BINS (MAX_BINS)
    ) u_bin_map (
        .bin_count   (bin_count_reg),
        .opcode      (opcode),
        .pixel_value (pixel_value),
        .read_index  (read_index),
        .sel         (sel)
    );

    assign rd_addr = sel.bin[BIN_AW-1:0];

    mgh_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (MAX_BINS)
    ) u_bin_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (upd_val),
        .re    (item_fire),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // A bin never written since the last clear reads as zero; a write in the
    // same cycle as the read is taken from the forward register instead.
    always_comb
    begin
        cur_val   = fwd_hit_reg ? fwd_data_reg : (rd_valid_reg ? ram_rdata : '0);
        inc_val   = (&cur_val) ? cur_val : cur_val + COUNT_WIDTH'(1);
        total_inc = (&pixel_total_reg) ? pixel_total_reg
                                       : pixel_total_reg + COUNT_WIDTH'(1);
        upd_val          = cur_val;
        bin_res          = '0;
        pixel_total_next = pixel_total_reg;
        case (op_reg)
            OP_ACCUM:
            begin
                if (counted_reg)
                begin
                    upd_val          = inc_val;
                    pixel_total_next = total_inc;
                end
                bin_res = upd_val;
            end
            OP_READ:
            begin
                bin_res = in_range_reg ? cur_val : '0;
            end
            OP_CLEAR:
            begin
                pixel_total_next = '0;
            end
            default:
            begin
                bin_res = '0;
            end
        endcase
    end

    assign ram_we  = exec_go && (op_reg == OP_ACCUM) && counted_reg;
    assign clr_now = cfg_hit || (exec_go && (op_reg == OP_CLEAR));

    always_comb
    begin
        valid_next = valid_reg;
        if (clr_now)
        begin
            valid_next = '0;
        end
        else if (ram_we)
        begin
            valid_next[addr_reg] = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_fire)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (exec_go && !item_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (exec_go)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            bin_count_reg    <= BIN_COUNT_RST;
            valid_reg        <= '0;
            pixel_total_reg  <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            valid_reg        <= valid_next;
            result_valid_reg <= result_valid_next;
            if (cfg_hit)
            begin
                bin_count_reg   <= pwdata[CFG_W-1:0];
                pixel_total_reg <= '0;
            end
            else if (exec_go)
            begin
                pixel_total_reg <= pixel_total_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            op_reg       <= opcode;
            counted_reg  <= pixel_counted;
            addr_reg     <= rd_addr;
            in_range_reg <= sel.in_range;
            rd_valid_reg <= (valid_reg[rd_addr] && !clr_now)
                            || (ram_we && (addr_reg == rd_addr));
            fwd_hit_reg  <= ram_we && (addr_reg == rd_addr);
            fwd_data_reg <= upd_val;
        end
        if (exec_go)
        begin
            bin_value_reg     <= OUT_W'(bin_res);
            total_counted_reg <= OUT_W'(pixel_total_next);
        end
    end

    assign result_valid  = result_valid_reg;
    assign bin_value     = bin_value_reg;
    assign total_counted = total_counted_reg;

    `MGH_ASSERT_NEXT(a_fire_enters_exec, item_fire, state_reg == S_EXEC, "accepted item not in execution")
    `MGH_ASSERT_NEXT(a_clear_result_zero, exec_go && op_reg == OP_CLEAR, result_valid_reg && bin_value_reg == '0 && total_counted_reg == '0 && pixel_total_reg == '0, "clear did not zero result and total")
    `MGH_ASSERT_IMPLIES(a_write_only_accum, ram_we, state_reg == S_EXEC && op_reg == OP_ACCUM && counted_reg, "bin write outside a counted accumulate")
    `MGH_ASSERT_NEXT(a_total_no_drop, exec_go && op_reg == OP_ACCUM && !cfg_hit, pixel_total_reg >= $past(pixel_total_reg), "total decreased on accumulate")

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for masked_gray_histogram_unit: a scoreboard class
// predicts every result from the accepted transactions; tasks drive APB and the stream.
// Depends on rtl/mgh_pkg.sv and the block itself.
`timescale 1ns / 1ps

module tb_top;
    import mgh_pkg::*;

    localparam logic [OP_W-1:0]         OP_UNUSED    = 2'd3;
    localparam logic [APB_ADDR_W-3:0]   REG_UNMAPPED = 1'b1;
    localparam int                      NUM_BINS     = MAX_BINS_DEF;

    class hist_scoreboard;
        typedef struct {
            logic [OP_W-1:0]  op;
            logic [OUT_W-1:0] bin_val;
            logic [OUT_W-1:0] total;
        } hist_result_t;

        logic [OUT_W-1:0] bin_counts [NUM_BINS];
        logic [OUT_W-1:0] pixel_total;
        logic [CFG_W-1:0] bin_count_reg;
        hist_result_t     awaited[$];
        int unsigned      mismatch_count;

        function void clear_bins();
            foreach (bin_counts[i])
                bin_counts[i] = '0;
            pixel_total = '0;
        endfunction

        function void reset_state();
            clear_bins();
            bin_count_reg  = BIN_COUNT_RST;
            mismatch_count = 0;
            awaited.delete();
        endfunction

        function int unsigned active_bins();
            int unsigned req;
            req = 32'(bin_count_reg);
            if (req == 0 || req > NUM_BINS)
                return NUM_BINS;
            return req;
        endfunction

        function logic [OUT_W-1:0] saturating_inc(logic [OUT_W-1:0] v);
            return (v == '1) ? v : v + OUT_W'(1);
        endfunction

        // Any write to the bin count starts a new histogram.
        function void write_register(logic [APB_ADDR_W-3:0] index, logic [31:0] data);
            if (index == REG_BIN_COUNT)
            begin
                bin_count_reg = data[CFG_W-1:0];
                clear_bins();
            end
        endfunction

        function void note_item(logic [OP_W-1:0] op, logic [PIX_W-1:0] pix, logic counted,
                                logic [PIX_W-1:0] ridx);
            int unsigned          size;
            logic [BIN_IDX_W-1:0] idx;
            hist_result_t         res;
            size        = active_bins();
            res.op      = op;
            res.bin_val = '0;
            case (op)
                OP_ACCUM:
                begin
                    idx = BIN_IDX_W'((32'(pix) * size) >> 8);
                    if (counted)
                    begin
                        bin_counts[idx] = saturating_inc(bin_counts[idx]);
                        pixel_total     = saturating_inc(pixel_total);
                    end
                    res.bin_val = bin_counts[idx];
                end
                OP_READ:
                    if (32'(ridx) < size)
                        res.bin_val = bin_counts[ridx];
                OP_CLEAR:
                    clear_bins();
                default: ;
            endcase
            res.total = pixel_total;
            awaited.insert(awaited.size(), res);
        endfunction

        function void report(string what, logic [OUT_W-1:0] exp_v, logic [OUT_W-1:0] act_v);
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, exp_v,
                         act_v);
        endfunction

        function void check_result(logic [OUT_W-1:0] bval, logic [OUT_W-1:0] tot);
            hist_result_t res;
            if (awaited.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result with no transaction outstanding (bin %0d, total %0d)",
                             $realtime, bval, tot);
                return;
            end
            res = awaited.pop_front();
            if (bval !== res.bin_val)
                report($sformatf("bin_value (op %0d)", res.op), res.bin_val, bval);
            if (tot !== res.total)
                report($sformatf("total_counted (op %0d)", res.op), res.total, tot);
        endfunction

        function int unsigned pending_count();
            return awaited.size();
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   item_valid;
    logic                   item_ready;
    logic [OP_W-1:0]        opcode;
    logic [PIX_W-1:0]       pixel_value;
    logic                   pixel_counted;
    logic [PIX_W-1:0]       read_index;
    logic                   result_valid;
    logic                   result_ready;
    logic [OUT_W-1:0]       bin_value;
    logic [OUT_W-1:0]       total_counted;

    hist_scoreboard hist_sb;
    bit             no_idle;

    masked_gray_histogram_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .opcode        (opcode),
        .pixel_value   (pixel_value),
        .pixel_counted (pixel_counted),
        .read_index    (read_index),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .bin_value     (bin_value),
        .total_counted (total_counted)
    );

    always #5 clk = ~clk;

    // Mostly no gap, sometimes a short one, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    task automatic cfg_write(input logic [APB_ADDR_W-3:0] index, input logic [31:0] data);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {index, 2'b00};
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        hist_sb.write_register(index, data);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Called and returns at a falling edge; valid is left high for a back-to-back transaction.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [PIX_W-1:0] pix,
                             input logic counted, input logic [PIX_W-1:0] ridx);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            item_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        opcode        = op;
        pixel_value   = pix;
        pixel_counted = counted;
        read_index    = ridx;
        item_valid    = 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        hist_sb.note_item(op, pix, counted, ridx);
        @(negedge clk);
    endtask

    task automatic drain_results();
        item_valid = 1'b0;
        while (hist_sb.pending_count() != 0)
            @(posedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic send_random_item();
        int unsigned      r;
        int unsigned      size;
        logic [OP_W-1:0]  op;
        logic [PIX_W-1:0] pix;
        logic             counted;
        logic [PIX_W-1:0] ridx;
        size    = hist_sb.active_bins();
        r       = $urandom_range(0, 99);
        pix     = PIX_W'($urandom_range(0, 255));
        counted = 1'($urandom_range(0, 1));
        ridx    = PIX_W'($urandom_range(0, 255));
        if (r < 70)
        begin
            op      = OP_ACCUM;
            counted = ($urandom_range(0, 7) != 0);
            if ($urandom_range(0, 9) == 0)
                pix = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        else if (r < 93)
        begin
            op = OP_READ;
            if ($urandom_range(0, 4) != 0)
                ridx = PIX_W'($urandom_range(0, size - 1));
        end
        else if (r < 97)
            op = OP_CLEAR;
        else
            op = OP_UNUSED;
        send_item(op, pix, counted, ridx);
    endtask

    initial
    begin
        result_ready = 1'b0;
        forever
        begin
            int unsigned stall_left;
            @(negedge clk);
            if (stall_left != 0)
            begin
                result_ready = 1'b0;
                stall_left--;
            end
            else
            begin
                result_ready = 1'b1;
                stall_left   = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
            end
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && result_ready)
                hist_sb.check_result(bin_value, total_counted);
        end
    end

    initial
    begin
        #6_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        logic [CFG_W-1:0] phase_bins [12];
        logic [31:0]      wdata;
        phase_bins = '{9'd2, 9'd1, 9'd256, 9'd3, 9'd0, 9'd255, 9'd17, 9'd511, 9'd100,
                       9'd257, 9'd128, 9'd5};
        hist_sb = new();
        hist_sb.reset_state();
        no_idle       = 1'b0;
        clk           = 1'b0;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        item_valid    = 1'b0;
        opcode        = OP_ACCUM;
        pixel_value   = '0;
        pixel_counted = 1'b0;
        read_index    = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset size of 256 bins: extremes, masked-out pixel, unused opcode and clear.
        send_item(OP_ACCUM, 8'h00, 1'b1, 8'h00);
        send_item(OP_ACCUM, 8'hFF, 1'b1, 8'hFF);
        send_item(OP_ACCUM, 8'hFF, 1'b0, 8'h00);
        send_item(OP_ACCUM, 8'h80, 1'b1, 8'h55);
        send_item(OP_READ, 8'hFF, 1'b1, 8'h00);
        send_item(OP_READ, 8'h00, 1'b0, 8'hFF);
        send_item(OP_READ, 8'hAA, 1'b1, 8'h80);
        send_item(OP_UNUSED, 8'hFF, 1'b1, 8'hFF);
        send_item(OP_CLEAR, 8'hFF, 1'b1, 8'hFF);
        send_item(OP_READ, 8'h00, 1'b0, 8'hFF);
        send_item(OP_ACCUM, 8'hFF, 1'b0, 8'h00);

        // A single bin: every pixel lands in bin 0, and bin 1 is out of range.
        drain_results();
        cfg_write(REG_BIN_COUNT, 32'd1);
        send_item(OP_ACCUM, 8'h00, 1'b1, 8'h00);
        send_item(OP_ACCUM, 8'hFF, 1'b1, 8'h01);
        send_item(OP_READ, 8'h00, 1'b0, 8'h00);
        send_item(OP_READ, 8'h00, 1'b0, 8'h01);

        // A write above the register list must leave the histogram alone.
        drain_results();
        cfg_write(REG_UNMAPPED, 32'h0000_01FF);
        send_item(OP_READ, 8'h00, 1'b0, 8'h00);

        drain_results();
        cfg_write(REG_BIN_COUNT, 32'd0);
        send_item(OP_ACCUM, 8'hFF, 1'b1, 8'h00);
        send_item(OP_READ, 8'h00, 1'b0, 8'hFF);

        drain_results();
        cfg_write(REG_BIN_COUNT, 32'hFFFF_FFFF);
        send_item(OP_ACCUM, 8'h01, 1'b1, 8'h00);
        send_item(OP_READ, 8'h00, 1'b0, 8'h01);

        drain_results();
        cfg_write(REG_BIN_COUNT, 32'd2);
        send_item(OP_ACCUM, 8'h7F, 1'b1, 8'h00);
        send_item(OP_ACCUM, 8'h80, 1'b1, 8'h00);
        send_item(OP_READ, 8'h00, 1'b0, 8'h02);

        for (int p = 0; p < 12; p++)
        begin
            drain_results();
            if (p % 3 == 1)
                cfg_write(REG_UNMAPPED, $urandom());
            wdata = $urandom();
            wdata[CFG_W-1:0] = phase_bins[p];
            cfg_write(REG_BIN_COUNT, wdata);
            no_idle = (p == 6);
            for (int n = 0; n < 113; n++)
            begin
                // One pause in mid-stream until every outstanding result is back.
                if (p == 3 && n == 56)
                    drain_results();
                send_random_item();
            end
            no_idle = 1'b0;
        end

        drain_results();
        repeat (5) @(negedge clk);
        if (hist_sb.mismatch_count == 0 && hist_sb.pending_count() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
